// ===== rtl/rgbyuv_pkg.sv =====
// Types and fixed constants shared by the RGB to YUV 4:2:0 converter.
// Depends on nothing; every other file of the block imports it.
package rgbyuv_pkg;

  // Widths of the configuration port and of the row counter, and the height limit
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int ROW_W        = 12;
  localparam int HEIGHT_LIMIT = 4096;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       frame_end;
  } out_result_t;

  // Per-channel sum of one horizontal pixel pair, one line store entry
  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } pair_sum_t;

endpackage

// ===== rtl/rgbyuv_line_store.sv =====
// Line store of pixel pair sums: one write port, one registered read port.
// Depends on rgbyuv_pkg for the entry type.
module rgbyuv_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  rgbyuv_pkg::pair_sum_t wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output rgbyuv_pkg::pair_sum_t rd_data
);
  import rgbyuv_pkg::*;

  pair_sum_t mem [DEPTH];
  pair_sum_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the read data until the next read so a stalled stage keeps it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/rgb_to_yuv420_converter.sv =====
// Top level of the RGB to YUV 4:2:0 converter (BT.601 integer coefficients).
// Depends on rgbyuv_pkg and rgbyuv_line_store.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------
//   in_      | input     | in_valid / in_stall  | in_pixel_t: red, green, blue
//   out_     | output    | out_valid/out_stall  | out_result_t: luma, chroma_valid,
//            |           |                      |   chroma_u/v, frame_end
//   cfg_     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data (13 bits)
//
// One item is accepted per cycle unless the input stalls; each item gives one
// result, registered in turn at the line store read, the average and luma stage
// and the chroma stage. The line store port pair sets the figure: at most one
// write or one read per item. Reset clears the counters, the held pixel and the
// pipeline valids and loads the reset configuration; the line store is not
// cleared, as every odd row reads only entries that the even row before it wrote.
// A stall on the output backs up through the stages; the input stalls only
// when all three stages are full and the output is stalled.
module rgb_to_yuv420_converter #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rgbyuv_pkg::in_pixel_t               in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rgbyuv_pkg::out_result_t             out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgbyuv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbyuv_pkg::CFG_W-1:0]        cfg_data
);
  import rgbyuv_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH);
  // Width that holds both the register value and MAX_WIDTH itself
  localparam int SW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int HW = CFG_W;

  // ---------------------------------------------------------------------
  // Configuration: keep the last column and last row, already clamped
  // ---------------------------------------------------------------------
  logic [SW-1:0] last_col_r, last_col_nxt;
  logic [HW-1:0] last_row_r, last_row_nxt;
  logic [SW-1:0] w_ext, w_clamp;
  logic [HW-1:0] h_clamp;

  assign cfg_ready = 1'b1;

  always_comb begin
    w_ext = SW'(cfg_data);
    if (w_ext < SW'(2)) begin
      w_clamp = SW'(2);
    end else if (w_ext > SW'(MAX_WIDTH)) begin
      w_clamp = SW'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    if (cfg_data < HW'(2)) begin
      h_clamp = HW'(2);
    end else if (cfg_data > HW'(HEIGHT_LIMIT)) begin
      h_clamp = HW'(HEIGHT_LIMIT);
    end else begin
      h_clamp = cfg_data;
    end
    // Round down to even, then step back to the last position
    last_col_nxt = (w_clamp & ~SW'(1)) - SW'(1);
    last_row_nxt = (h_clamp & ~HW'(1)) - HW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= SW'(FRAME_WIDTH_RST - CFG_W'(1));
      last_row_r <= FRAME_HEIGHT_RST - HW'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  last_col_r <= last_col_nxt;
        CFG_FRAME_HEIGHT: last_row_r <= last_row_nxt;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_ready, s2_ready, s1_ready, accept;

  assign out_ready = !out_valid_r || !out_stall;
  assign s2_ready  = !s2_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign accept    = in_valid && s1_ready;

  // ---------------------------------------------------------------------
  // Stage 0: raster counters, pair sums, line store access
  // ---------------------------------------------------------------------
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  in_pixel_t        held_r;
  pair_sum_t        pair_sum;
  pair_sum_t        ls_rdata;
  logic [AW-1:0]    ls_addr;
  logic             ls_wr_en, ls_rd_en;
  logic             row_end, last_row, blk_done, fend;

  assign pair_sum.red   = 9'(in_data.red)   + 9'(held_r.red);
  assign pair_sum.green = 9'(in_data.green) + 9'(held_r.green);
  assign pair_sum.blue  = 9'(in_data.blue)  + 9'(held_r.blue);

  assign ls_addr  = AW'(col_r >> 1);
  // Even row writes the pair sum, odd row reads it back; a read of an entry
  // always comes at least one row after its write, so no forwarding is needed
  assign ls_wr_en = accept && col_r[0] && !row_r[0];
  assign ls_rd_en = accept && col_r[0] && row_r[0];
  assign blk_done = col_r[0] && row_r[0];

  assign row_end  = SW'(col_r) >= last_col_r;
  assign last_row = HW'(row_r) >= last_row_r;
  assign fend     = row_end && last_row;

  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (row_end) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      // Hold the first pixel of each pair
      if (!col_r[0]) begin
        held_r <= in_data;
      end
    end
  end

  rgbyuv_line_store #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ls_wr_en),
    .wr_addr (ls_addr),
    .wr_data (pair_sum),
    .rd_en   (ls_rd_en),
    .rd_addr (ls_addr),
    .rd_data (ls_rdata)
  );

  // ---------------------------------------------------------------------
  // Stage 1: luma, block averages (line store data arrives here)
  // ---------------------------------------------------------------------
  in_pixel_t s1_pix_r;
  pair_sum_t s1_pair_r;
  logic      s1_blk_r, s1_fend_r;
  logic [15:0] luma_acc;
  logic [9:0]  sum_r4, sum_g4, sum_b4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_data;
      s1_pair_r <= pair_sum;
      s1_blk_r  <= blk_done;
      s1_fend_r <= fend;
    end
  end

  assign luma_acc = 16'(s1_pix_r.red)   * 16'd77
                  + 16'(s1_pix_r.green) * 16'd150
                  + 16'(s1_pix_r.blue)  * 16'd29;

  assign sum_r4 = 10'(s1_pair_r.red)   + 10'(ls_rdata.red);
  assign sum_g4 = 10'(s1_pair_r.green) + 10'(ls_rdata.green);
  assign sum_b4 = 10'(s1_pair_r.blue)  + 10'(ls_rdata.blue);

  // ---------------------------------------------------------------------
  // Stage 2: chroma from the block averages
  // ---------------------------------------------------------------------
  logic [7:0]  s2_luma_r, s2_avg_r_r, s2_avg_g_r, s2_avg_b_r;
  logic        s2_blk_r, s2_fend_r;
  logic [17:0] u_acc, v_acc;
  out_result_t res_nxt, out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_luma_r  <= luma_acc[15:8];
      s2_avg_r_r <= sum_r4[9:2];
      s2_avg_g_r <= sum_g4[9:2];
      s2_avg_b_r <= sum_b4[9:2];
      s2_blk_r   <= s1_blk_r;
      s2_fend_r  <= s1_fend_r;
    end
  end

  // Two's complement sums; bits 15:8 are the floored quotient by 256
  assign u_acc = 18'(s2_avg_b_r) * 18'd127
               - 18'(s2_avg_r_r) * 18'd43
               - 18'(s2_avg_g_r) * 18'd84;
  assign v_acc = 18'(s2_avg_r_r) * 18'd127
               - 18'(s2_avg_g_r) * 18'd106
               - 18'(s2_avg_b_r) * 18'd21;

  always_comb begin
    res_nxt.luma         = s2_luma_r;
    res_nxt.chroma_valid = s2_blk_r;
    res_nxt.chroma_u     = s2_blk_r ? u_acc[15:8] + 8'd128 : 8'd0;
    res_nxt.chroma_v     = s2_blk_r ? v_acc[15:8] + 8'd128 : 8'd0;
    res_nxt.frame_end    = s2_fend_r;
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Chroma of a completed block never reaches the ends of the byte range
  a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.chroma_valid |->
      out_data_r.chroma_u != 8'd0 && out_data_r.chroma_u != 8'd255 &&
      out_data_r.chroma_v != 8'd0 && out_data_r.chroma_v != 8'd255)
    else $error("chroma out of range");

  // The line store is never written and read by the same item
  a_ls_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ls_wr_en && ls_rd_en))
    else $error("line store read and write together");

  // The last pixel of a frame restarts both counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fend |=> col_r == '0 && row_r == '0)
    else $error("counters did not restart at frame end");

  // The input stalls only while every stage holds an item and the output is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s2_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
